// ----- src/gbt_pkg.sv -----
// ============================================================================
// gbt_pkg: shared types and constants for the green blob box tracker
// Holds the transaction structs, register indexes, reset values and the
// controller state type used by the tracker modules.
// ============================================================================
package gbt_pkg;

    localparam int MAX_BLOBS_DEF  = 32;
    localparam int COORD_BITS_DEF = 10;
    localparam int RESULT_CAP     = 32;

    localparam int COLOR_W    = 8;
    localparam int RB_W       = 9;
    localparam int MARGIN_W   = 8;
    localparam int PORT_XY_W  = 10;
    localparam int SLOT_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int COUNT_W    = $clog2(RESULT_CAP + 1);

    localparam logic [RB_W-1:0]     RB_SUM_LIMIT_RST = 9'd10;
    localparam logic [COLOR_W-1:0]  GREEN_MIN_RST    = 8'd10;
    localparam logic [MARGIN_W-1:0] NEAR_MARGIN_RST  = 8'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RB_SUM_LIMIT = 2'd0,
        CFG_GREEN_MIN    = 2'd1,
        CFG_NEAR_MARGIN  = 2'd2
    } cfg_index_t;

    typedef enum logic {
        ST_RUN  = 1'b0,
        ST_READ = 1'b1
    } state_t;

    typedef struct packed {
        logic [COLOR_W-1:0]   red;
        logic [COLOR_W-1:0]   green;
        logic [COLOR_W-1:0]   blue;
        logic [PORT_XY_W-1:0] x_pos;
        logic [PORT_XY_W-1:0] y_pos;
        logic                 frame_end;
    } pixel_t;

    typedef struct packed {
        logic [PORT_XY_W-1:0] box_left;
        logic [PORT_XY_W-1:0] box_top;
        logic [PORT_XY_W-1:0] box_width;
        logic [PORT_XY_W-1:0] box_height;
        logic [SLOT_W-1:0]    blob_slot;
        logic                 has_blob;
        logic                 table_overflow;
        logic                 last_result;
    } result_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic mark;
        logic shift;
    } cell_ctrl_t;

endpackage

// ----- src/gbt_cell.sv -----
// ============================================================================
// gbt_cell: one blob slot of the tracker chain
// Holds one box, tests a marked pixel against it, grows it, claims itself for
// a new blob when it is the lowest free slot, and shifts toward the head
// during readout.
// ============================================================================
module gbt_cell #(
    parameter int COORD_BITS = gbt_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gbt_pkg::cell_ctrl_t           ctrl,
    input  logic [COORD_BITS-1:0]         pixel_x,
    input  logic [COORD_BITS-1:0]         pixel_y,
    input  logic [gbt_pkg::MARGIN_W-1:0]  margin,
    input  logic                          joined,
    input  logic                          free_in,
    output logic                          free_out,
    input  logic                          join_in,
    output logic                          join_out,
    input  logic                          tail_in,
    output logic                          tail_out,
    input  logic                          nb_valid,
    input  logic [COORD_BITS-1:0]         nb_left,
    input  logic [COORD_BITS-1:0]         nb_top,
    input  logic [COORD_BITS-1:0]         nb_width,
    input  logic [COORD_BITS-1:0]         nb_height,
    output logic                          valid,
    output logic [COORD_BITS-1:0]         left,
    output logic [COORD_BITS-1:0]         top,
    output logic [COORD_BITS-1:0]         width,
    output logic [COORD_BITS-1:0]         height
);

    localparam int BASE_W = (COORD_BITS > gbt_pkg::MARGIN_W) ? COORD_BITS
                                                             : gbt_pkg::MARGIN_W;
    localparam int EW     = BASE_W + 2;

    logic                  valid_reg, valid_next;
    logic [COORD_BITS-1:0] left_reg, left_next;
    logic [COORD_BITS-1:0] top_reg, top_next;
    logic [COORD_BITS-1:0] width_reg, width_next;
    logic [COORD_BITS-1:0] height_reg, height_next;

    logic [EW-1:0]         x_e, y_e, l_e, t_e, w_e, h_e, d_e;
    logic                  near;
    logic                  take;
    logic [COORD_BITS:0]   right, bottom, right_new, bottom_new;
    logic [COORD_BITS-1:0] left_new, top_new;

    // Near test at full precision: x + d > l is the same as x > l - d.
    always_comb
    begin
        x_e  = EW'(pixel_x);
        y_e  = EW'(pixel_y);
        l_e  = EW'(left_reg);
        t_e  = EW'(top_reg);
        w_e  = EW'(width_reg);
        h_e  = EW'(height_reg);
        d_e  = EW'(margin);
        near = valid_reg
            && (x_e + d_e > l_e) && (x_e < l_e + w_e + d_e)
            && (y_e + d_e > t_e) && (y_e < t_e + h_e + d_e);
    end

    assign join_out = join_in | near;
    assign free_out = free_in | ~valid_reg;
    assign tail_out = tail_in | valid_reg;
    assign take     = ctrl.mark & ~joined & ~valid_reg & ~free_in;

    always_comb
    begin
        right      = {1'b0, left_reg} + {1'b0, width_reg};
        bottom     = {1'b0, top_reg} + {1'b0, height_reg};
        left_new   = (pixel_x < left_reg) ? pixel_x : left_reg;
        top_new    = (pixel_y < top_reg) ? pixel_y : top_reg;
        right_new  = ({1'b0, pixel_x} > right) ? {1'b0, pixel_x} : right;
        bottom_new = ({1'b0, pixel_y} > bottom) ? {1'b0, pixel_y} : bottom;
    end

    always_comb
    begin
        valid_next  = valid_reg;
        left_next   = left_reg;
        top_next    = top_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (ctrl.shift)
        begin
            valid_next  = nb_valid;
            left_next   = nb_left;
            top_next    = nb_top;
            width_next  = nb_width;
            height_next = nb_height;
        end
        else if (ctrl.mark && near)
        begin
            left_next   = left_new;
            top_next    = top_new;
            width_next  = COORD_BITS'(right_new - {1'b0, left_new});
            height_next = COORD_BITS'(bottom_new - {1'b0, top_new});
        end
        else if (take)
        begin
            valid_next  = 1'b1;
            left_next   = pixel_x;
            top_next    = pixel_y;
            width_next  = '0;
            height_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg   <= left_next;
        top_reg    <= top_next;
        width_reg  <= width_next;
        height_reg <= height_next;
    end

    assign valid  = valid_reg;
    assign left   = left_reg;
    assign top    = top_reg;
    assign width  = width_reg;
    assign height = height_reg;

endmodule

// ----- src/gbt_chain.sv -----
// ============================================================================
// gbt_chain: row of blob cells
// Wires the cells into a chain: free-slot and join flags ripple from the head
// upward, the occupancy flag ripples down, and boxes shift toward the head.
// ============================================================================
module gbt_chain #(
    parameter int MAX_BLOBS  = gbt_pkg::MAX_BLOBS_DEF,
    parameter int COORD_BITS = gbt_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gbt_pkg::cell_ctrl_t           ctrl,
    input  logic [COORD_BITS-1:0]         pixel_x,
    input  logic [COORD_BITS-1:0]         pixel_y,
    input  logic [gbt_pkg::MARGIN_W-1:0]  margin,
    output logic                          joined,
    output logic                          free_any,
    output logic                          rest_valid,
    output logic                          head_valid,
    output logic [COORD_BITS-1:0]         head_left,
    output logic [COORD_BITS-1:0]         head_top,
    output logic [COORD_BITS-1:0]         head_width,
    output logic [COORD_BITS-1:0]         head_height
);

    logic                  free_chain [MAX_BLOBS+1];
    logic                  join_chain [MAX_BLOBS+1];
    logic                  tail_chain [MAX_BLOBS+1];
    logic                  valid_w    [MAX_BLOBS+1];
    logic [COORD_BITS-1:0] left_w     [MAX_BLOBS+1];
    logic [COORD_BITS-1:0] top_w      [MAX_BLOBS+1];
    logic [COORD_BITS-1:0] width_w    [MAX_BLOBS+1];
    logic [COORD_BITS-1:0] height_w   [MAX_BLOBS+1];

    assign free_chain[0]         = 1'b0;
    assign join_chain[0]         = 1'b0;
    assign tail_chain[MAX_BLOBS] = 1'b0;
    // The top cell shifts in an empty slot, which clears the table on readout.
    assign valid_w[MAX_BLOBS]    = 1'b0;
    assign left_w[MAX_BLOBS]     = '0;
    assign top_w[MAX_BLOBS]      = '0;
    assign width_w[MAX_BLOBS]    = '0;
    assign height_w[MAX_BLOBS]   = '0;

    genvar i;
    generate
        for (i = 0; i < MAX_BLOBS; i++)
        begin : g_cell
            gbt_cell #(
                .COORD_BITS (COORD_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .pixel_x   (pixel_x),
                .pixel_y   (pixel_y),
                .margin    (margin),
                .joined    (joined),
                .free_in   (free_chain[i]),
                .free_out  (free_chain[i+1]),
                .join_in   (join_chain[i]),
                .join_out  (join_chain[i+1]),
                .tail_in   (tail_chain[i+1]),
                .tail_out  (tail_chain[i]),
                .nb_valid  (valid_w[i+1]),
                .nb_left   (left_w[i+1]),
                .nb_top    (top_w[i+1]),
                .nb_width  (width_w[i+1]),
                .nb_height (height_w[i+1]),
                .valid     (valid_w[i]),
                .left      (left_w[i]),
                .top       (top_w[i]),
                .width     (width_w[i]),
                .height    (height_w[i])
            );
        end
    endgenerate

    assign joined      = join_chain[MAX_BLOBS];
    assign free_any    = free_chain[MAX_BLOBS];
    assign rest_valid  = tail_chain[1];
    assign head_valid  = valid_w[0];
    assign head_left   = left_w[0];
    assign head_top    = top_w[0];
    assign head_width  = width_w[0];
    assign head_height = height_w[0];

endmodule

// ----- src/green_blob_bounding_box_tracker_core.sv -----
// ============================================================================
// green_blob_bounding_box_tracker_core: streaming green blob box tracker
// Marks green pixels of a raster stream, grows blob boxes in a chain of slot
// cells and reads the boxes out at the end of each frame.
// ============================================================================
// Usage:
// Pixels enter on the pixel channel (pixel_valid, pixel_stall, pixel), one
// transaction per pixel in raster order. While a frame streams in, a pixel is
// taken every cycle: all slot cells test and update in the cycle of the
// transaction, with the free-slot and join flags rippling combinationally
// through the cell chain.
// The pixel flagged frame_end starts readout: pixel_stall rises and the cells
// shift toward the head, one slot per cycle unless a valid result is stalled,
// emitting one result transaction per valid blob in slot order, or a single
// empty result when none. Readout ends once no valid slot is left behind the
// head or the last slot is read; results are registered after ST_READ is set.
// A valid result holds while result_stall is high and the chain freezes with
// it. The configuration channel is always ready; write it only while idle.
// Reset clears the slot table, the overflow flag and the registers to their
// defaults; the tracker is ready for pixels right after reset.
// ============================================================================
module green_blob_bounding_box_tracker_core #(
    parameter int MAX_BLOBS  = gbt_pkg::MAX_BLOBS_DEF,
    parameter int COORD_BITS = gbt_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pixel_valid,
    output logic                            pixel_stall,
    input  gbt_pkg::pixel_t                 pixel,
    output logic                            result_valid,
    input  logic                            result_stall,
    output gbt_pkg::result_t                result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gbt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gbt_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1;

    gbt_pkg::state_t                 state_reg, state_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic [gbt_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic                            overflow_reg, overflow_next;
    logic                            result_valid_reg, result_valid_next;
    gbt_pkg::result_t                result_reg, result_next;
    logic [gbt_pkg::RB_W-1:0]        rb_sum_limit_reg;
    logic [gbt_pkg::COLOR_W-1:0]     green_min_reg;
    logic [gbt_pkg::MARGIN_W-1:0]    near_margin_reg;

    gbt_pkg::cell_ctrl_t             ctrl;
    logic [COORD_BITS-1:0]           pixel_x, pixel_y;
    logic                            accept, marked, advance, emit, empty, done;
    logic                            joined, free_any, rest_valid, head_valid;
    logic [COORD_BITS-1:0]           head_left, head_top, head_width, head_height;

    assign cfg_ready   = 1'b1;
    assign pixel_stall = (state_reg != gbt_pkg::ST_RUN);
    assign accept      = pixel_valid & ~pixel_stall;
    assign pixel_x     = COORD_BITS'(pixel.x_pos);
    assign pixel_y     = COORD_BITS'(pixel.y_pos);
    assign marked      = ({1'b0, pixel.red} + {1'b0, pixel.blue} < rb_sum_limit_reg)
                      && (pixel.green > green_min_reg);
    assign advance     = (state_reg == gbt_pkg::ST_READ)
                      && (!result_valid_reg || !result_stall);

    always_comb
    begin
        ctrl.mark  = accept & marked;
        ctrl.shift = advance;
    end

    gbt_chain #(
        .MAX_BLOBS  (MAX_BLOBS),
        .COORD_BITS (COORD_BITS)
    ) u_chain (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .margin      (near_margin_reg),
        .joined      (joined),
        .free_any    (free_any),
        .rest_valid  (rest_valid),
        .head_valid  (head_valid),
        .head_left   (head_left),
        .head_top    (head_top),
        .head_width  (head_width),
        .head_height (head_height)
    );

    // Readout: the head cell is examined each time the chain shifts.
    always_comb
    begin
        empty = (idx_reg == '0) && !head_valid && !rest_valid;
        emit  = advance && (empty
             || (head_valid && (count_reg < gbt_pkg::COUNT_W'(gbt_pkg::RESULT_CAP))));
        done  = advance && (!rest_valid || (idx_reg == IDX_W'(MAX_BLOBS - 1)));
    end

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        count_next        = count_reg;
        overflow_next     = overflow_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            gbt_pkg::ST_RUN:
            begin
                if (ctrl.mark && !joined && !free_any)
                begin
                    overflow_next = 1'b1;
                end
                if (accept && pixel.frame_end)
                begin
                    state_next = gbt_pkg::ST_READ;
                end
            end
            gbt_pkg::ST_READ:
            begin
                if (emit)
                begin
                    result_valid_next          = 1'b1;
                    result_next.box_left       = empty ? '0 : gbt_pkg::PORT_XY_W'(head_left);
                    result_next.box_top        = empty ? '0 : gbt_pkg::PORT_XY_W'(head_top);
                    result_next.box_width      = empty ? '0 : gbt_pkg::PORT_XY_W'(head_width);
                    result_next.box_height     = empty ? '0 : gbt_pkg::PORT_XY_W'(head_height);
                    result_next.blob_slot      = gbt_pkg::SLOT_W'(idx_reg);
                    result_next.has_blob       = !empty;
                    result_next.table_overflow = overflow_reg;
                    result_next.last_result    = empty || !rest_valid
                        || (count_reg == gbt_pkg::COUNT_W'(gbt_pkg::RESULT_CAP - 1));
                    count_next                 = count_reg + 1'b1;
                end
                if (advance)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (done)
                begin
                    state_next    = gbt_pkg::ST_RUN;
                    idx_next      = '0;
                    count_next    = '0;
                    overflow_next = 1'b0;
                end
            end
            default:
            begin
                state_next = gbt_pkg::ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= gbt_pkg::ST_RUN;
            idx_reg          <= '0;
            count_reg        <= '0;
            overflow_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            count_reg        <= count_next;
            overflow_reg     <= overflow_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rb_sum_limit_reg <= gbt_pkg::RB_SUM_LIMIT_RST;
            green_min_reg    <= gbt_pkg::GREEN_MIN_RST;
            near_margin_reg  <= gbt_pkg::NEAR_MARGIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gbt_pkg::CFG_RB_SUM_LIMIT: rb_sum_limit_reg <= cfg_data;
                gbt_pkg::CFG_GREEN_MIN:    green_min_reg    <= gbt_pkg::COLOR_W'(cfg_data);
                gbt_pkg::CFG_NEAR_MARGIN:  near_margin_reg  <= gbt_pkg::MARGIN_W'(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // The last pixel of a frame always hands the table over to readout.
    a_frame_end_reads: assert property (@(posedge clk) disable iff (!rst_n)
        accept && pixel.frame_end |=> state_reg == gbt_pkg::ST_READ)
        else $error("frame end did not start readout");

    // An empty frame yields exactly one result, which closes the readout.
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.has_blob |-> result_reg.last_result)
        else $error("empty result not flagged as last");

    // Readout counters are back at zero whenever pixels are accepted.
    a_counters_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == gbt_pkg::ST_RUN |-> idx_reg == '0 && count_reg == '0)
        else $error("readout counters not cleared");

    // The table is empty once a readout has finished.
    a_table_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !head_valid && !rest_valid && !overflow_reg)
        else $error("slot table not cleared after readout");
`endif

endmodule

// ----- sim/tb_green_blob_bounding_box_tracker_core.sv -----
// ============================================================================
// tb_green_blob_bounding_box_tracker_core: testbench for the blob box tracker
// Streams pixel frames into the tracker under several threshold settings and
// checks every box readout against a cycle-free model of the slot table.
// Both channels idle at random, and the receiver holds off for a long stretch.
// ============================================================================
`timescale 1ns / 1ps

module tb_green_blob_bounding_box_tracker_core;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int SLOTS         = gbt_pkg::MAX_BLOBS_DEF;
    localparam int MAX_WAIT      = 7;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = gbt_pkg::MAX_BLOBS_DEF + 8;
    localparam int IDLE_LIMIT    = 1000;
    localparam int COORD_MAX     = 1023;
    localparam logic [gbt_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           pixel_valid  = 1'b0;
    logic                           pixel_stall;
    gbt_pkg::pixel_t                pixel        = '0;
    logic                           result_valid;
    logic                           result_stall = 1'b0;
    gbt_pkg::result_t               result;
    logic                           cfg_valid    = 1'b0;
    logic                           cfg_ready;
    logic [gbt_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [gbt_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

    // Local copy of the thresholds and of the slot table.
    logic [gbt_pkg::RB_W-1:0]      rb_limit    = gbt_pkg::RB_SUM_LIMIT_RST;
    logic [gbt_pkg::COLOR_W-1:0]   green_floor = gbt_pkg::GREEN_MIN_RST;
    logic [gbt_pkg::MARGIN_W-1:0]  margin      = gbt_pkg::NEAR_MARGIN_RST;
    bit                            slot_used [SLOTS];
    logic [gbt_pkg::PORT_XY_W-1:0] slot_left [SLOTS];
    logic [gbt_pkg::PORT_XY_W-1:0] slot_top [SLOTS];
    logic [gbt_pkg::PORT_XY_W-1:0] slot_w [SLOTS];
    logic [gbt_pkg::PORT_XY_W-1:0] slot_h [SLOTS];
    bit                            table_full_seen = 1'b0;

    gbt_pkg::pixel_t  pending_pixels [$];
    gbt_pkg::result_t expected_boxes [$];

    bit pix_fire   = 1'b0;
    bit res_fire   = 1'b0;
    bit quiet_mode = 1'b0;
    int gap_left   = 0;
    int wait_left  = 0;
    int hold_left  = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int idle_cycles   = 0;

    int errors          = 0;
    int pixels_queued   = 0;
    int pixels_taken    = 0;
    int results_checked = 0;
    int frames_closed   = 0;
    int overflow_frames = 0;

    green_blob_bounding_box_tracker_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // The near test runs at full precision, so an edge minus the margin may
    // go below zero.
    function automatic bit near_box(int i, int x, int y);
        int d;
        d = int'(margin);
        return x > int'(slot_left[i]) - d
            && x < int'(slot_left[i]) + int'(slot_w[i]) + d
            && y > int'(slot_top[i]) - d
            && y < int'(slot_top[i]) + int'(slot_h[i]) + d;
    endfunction

    task automatic grow_box(int i, int x, int y);
        int l;
        int t;
        int r;
        int b;
        l = int'(slot_left[i]);
        t = int'(slot_top[i]);
        r = l + int'(slot_w[i]);
        b = t + int'(slot_h[i]);
        if (x < l) l = x;
        if (x > r) r = x;
        if (y < t) t = y;
        if (y > b) b = y;
        slot_left[i] = gbt_pkg::PORT_XY_W'(l);
        slot_top[i]  = gbt_pkg::PORT_XY_W'(t);
        slot_w[i]    = gbt_pkg::PORT_XY_W'(r - l);
        slot_h[i]    = gbt_pkg::PORT_XY_W'(b - t);
    endtask

    task automatic track_pixel(input gbt_pkg::pixel_t p);
        bit               joined;
        int               free_slot;
        int               total;
        int               n;
        gbt_pkg::result_t box;
        if (int'(p.red) + int'(p.blue) < int'(rb_limit) && p.green > green_floor)
        begin
            joined    = 1'b0;
            free_slot = -1;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!slot_used[i])
                begin
                    if (free_slot < 0) free_slot = i;
                end
                else if (near_box(i, int'(p.x_pos), int'(p.y_pos)))
                begin
                    grow_box(i, int'(p.x_pos), int'(p.y_pos));
                    joined = 1'b1;
                end
            end
            if (!joined)
            begin
                if (free_slot >= 0)
                begin
                    slot_used[free_slot] = 1'b1;
                    slot_left[free_slot] = p.x_pos;
                    slot_top[free_slot]  = p.y_pos;
                    slot_w[free_slot]    = '0;
                    slot_h[free_slot]    = '0;
                end
                else
                    table_full_seen = 1'b1;
            end
        end
        if (p.frame_end)
        begin
            total = 0;
            for (int i = 0; i < SLOTS; i++)
                if (slot_used[i]) total++;
            if (total > gbt_pkg::RESULT_CAP) total = gbt_pkg::RESULT_CAP;
            n = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (slot_used[i] && n < total)
                begin
                    box.box_left       = slot_left[i];
                    box.box_top        = slot_top[i];
                    box.box_width      = slot_w[i];
                    box.box_height     = slot_h[i];
                    box.blob_slot      = gbt_pkg::SLOT_W'(i);
                    box.has_blob       = 1'b1;
                    box.table_overflow = table_full_seen;
                    box.last_result    = (n == total - 1);
                    expected_boxes.push_back(box);
                    n++;
                end
            end
            if (total == 0)
            begin
                box                = '0;
                box.table_overflow = table_full_seen;
                box.last_result    = 1'b1;
                expected_boxes.push_back(box);
            end
            frames_closed++;
            if (table_full_seen) overflow_frames++;
            for (int i = 0; i < SLOTS; i++)
                slot_used[i] = 1'b0;
            table_full_seen = 1'b0;
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Scoreboard: result checks first, then the model takes the new pixel.
    always @(posedge clk)
    begin
        gbt_pkg::result_t want;
        if (rst_n)
        begin
            pix_fire <= pixel_valid && !pixel_stall;
            res_fire <= result_valid && !result_stall;
            if (result_valid && !result_stall)
            begin
                results_checked++;
                if (expected_boxes.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %p", $time, result);
                end
                else
                begin
                    want = expected_boxes.pop_front();
                    check_field("box_left", 32'(want.box_left), 32'(result.box_left));
                    check_field("box_top", 32'(want.box_top), 32'(result.box_top));
                    check_field("box_width", 32'(want.box_width), 32'(result.box_width));
                    check_field("box_height", 32'(want.box_height),
                                32'(result.box_height));
                    check_field("blob_slot", 32'(want.blob_slot), 32'(result.blob_slot));
                    check_field("has_blob", 32'(want.has_blob), 32'(result.has_blob));
                    check_field("table_overflow", 32'(want.table_overflow),
                                32'(result.table_overflow));
                    check_field("last_result", 32'(want.last_result),
                                32'(result.last_result));
                end
            end
            if (pixel_valid && !pixel_stall)
            begin
                pixels_taken++;
                track_pixel(pixel);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gbt_pkg::CFG_RB_SUM_LIMIT: rb_limit    <= cfg_data;
                    gbt_pkg::CFG_GREEN_MIN:    green_floor <= cfg_data[gbt_pkg::COLOR_W-1:0];
                    gbt_pkg::CFG_NEAR_MARGIN:  margin      <= cfg_data[gbt_pkg::MARGIN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("Verification failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Pixel driver: a stalled transaction keeps its payload until accepted.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (pix_fire) gap_left = quiet_mode ? 0 : $urandom_range(0, MAX_WAIT);
            if (!pixel_valid || pix_fire)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    pixel_valid <= 1'b0;
                end
                else if (pending_pixels.size() != 0)
                begin
                    pixel       <= pending_pixels.pop_front();
                    pixel_valid <= 1'b1;
                end
                else
                    pixel_valid <= 1'b0;
            end
        end
    end

    // Result receiver: a short random stall after each transaction, and on
    // request one long hold-off that starts with the next waiting result.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_fire) wait_left = quiet_mode ? 0 : $urandom_range(0, MAX_WAIT);
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (hold_served != hold_requests && result_valid)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
                result_stall <= 1'b1;
            end
            else if (wait_left > 0)
            begin
                wait_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    task automatic write_reg(input logic [gbt_pkg::CFG_IDX_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= gbt_pkg::CFG_DATA_W'(val);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_thresholds(int limit, int gmin, int near);
        write_reg(gbt_pkg::CFG_RB_SUM_LIMIT, limit);
        write_reg(gbt_pkg::CFG_GREEN_MIN, gmin);
        write_reg(gbt_pkg::CFG_NEAR_MARGIN, near);
    endtask

    task automatic queue_pixel(input gbt_pkg::pixel_t p);
        pending_pixels.push_back(p);
        pixels_queued++;
    endtask

    task automatic push_px(int r, int g, int b, int x, int y, bit fe);
        gbt_pkg::pixel_t p;
        p.red       = gbt_pkg::COLOR_W'(r);
        p.green     = gbt_pkg::COLOR_W'(g);
        p.blue      = gbt_pkg::COLOR_W'(b);
        p.x_pos     = gbt_pkg::PORT_XY_W'(x);
        p.y_pos     = gbt_pkg::PORT_XY_W'(y);
        p.frame_end = fe;
        queue_pixel(p);
    endtask

    task automatic wait_drained();
        while (pixels_taken != pixels_queued || expected_boxes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic gbt_pkg::pixel_t noise_pixel();
        gbt_pkg::pixel_t p;
        p.red       = gbt_pkg::COLOR_W'($urandom);
        p.green     = gbt_pkg::COLOR_W'($urandom);
        p.blue      = gbt_pkg::COLOR_W'($urandom);
        p.x_pos     = gbt_pkg::PORT_XY_W'($urandom);
        p.y_pos     = gbt_pkg::PORT_XY_W'($urandom);
        p.frame_end = ($urandom_range(0, 15) == 0);
        return p;
    endfunction

    // A pixel that passes the current thresholds, where any can.
    function automatic gbt_pkg::pixel_t green_pixel(int x, int y);
        gbt_pkg::pixel_t p;
        int              top;
        p = noise_pixel();
        p.x_pos     = gbt_pkg::PORT_XY_W'(x);
        p.y_pos     = gbt_pkg::PORT_XY_W'(y);
        p.frame_end = 1'b0;
        if (rb_limit != 0 && green_floor != '1)
        begin
            p.green = gbt_pkg::COLOR_W'($urandom_range(int'(green_floor) + 1, 255));
            top = (rb_limit > 256) ? 255 : int'(rb_limit) - 1;
            p.red = gbt_pkg::COLOR_W'($urandom_range(0, top));
            top = int'(rb_limit) - 1 - int'(p.red);
            if (top > 255) top = 255;
            p.blue = gbt_pkg::COLOR_W'($urandom_range(0, top));
        end
        return p;
    endfunction

    function automatic gbt_pkg::pixel_t plain_pixel(int x, int y);
        gbt_pkg::pixel_t p;
        p.red       = gbt_pkg::COLOR_W'($urandom);
        p.green     = gbt_pkg::COLOR_W'($urandom_range(0, green_floor));
        p.blue      = gbt_pkg::COLOR_W'($urandom);
        p.x_pos     = gbt_pkg::PORT_XY_W'(x);
        p.y_pos     = gbt_pkg::PORT_XY_W'(y);
        p.frame_end = 1'b0;
        return p;
    endfunction

    // Small raster frame at a random origin with a few green spots and some
    // fully random pixels mixed in.
    task automatic add_frame(int w, int h, int spots, int noise_pct);
        int              x0;
        int              y0;
        int              sx [4];
        int              sy [4];
        int              sw [4];
        int              sh [4];
        bit              hit;
        gbt_pkg::pixel_t p;
        x0 = $urandom_range(0, COORD_MAX + 1 - w);
        y0 = $urandom_range(0, COORD_MAX + 1 - h);
        for (int s = 0; s < spots; s++)
        begin
            sx[s] = $urandom_range(0, w - 1);
            sy[s] = $urandom_range(0, h - 1);
            sw[s] = $urandom_range(0, 2);
            sh[s] = $urandom_range(0, 2);
        end
        for (int yy = 0; yy < h; yy++)
        begin
            for (int xx = 0; xx < w; xx++)
            begin
                hit = 1'b0;
                for (int s = 0; s < spots; s++)
                    if (xx >= sx[s] && xx <= sx[s] + sw[s] && yy >= sy[s]
                        && yy <= sy[s] + sh[s])
                        hit = 1'b1;
                if ($urandom_range(0, 99) < noise_pct)
                    p = noise_pixel();
                else if (hit)
                    p = green_pixel(x0 + xx, y0 + yy);
                else
                    p = plain_pixel(x0 + xx, y0 + yy);
                if (yy == h - 1 && xx == w - 1) p.frame_end = 1'b1;
                queue_pixel(p);
            end
        end
    endtask

    task automatic add_noise(int n);
        gbt_pkg::pixel_t p;
        for (int i = 0; i < n; i++)
        begin
            p = noise_pixel();
            if (i == n - 1) p.frame_end = 1'b1;
            queue_pixel(p);
        end
    endtask

    // Scattered green pixels; with a zero margin each one wants its own slot.
    task automatic add_crowd(int n);
        gbt_pkg::pixel_t p;
        for (int i = 0; i < n; i++)
        begin
            p = green_pixel($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
            if (i == n - 1) p.frame_end = 1'b1;
            queue_pixel(p);
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // A write to an unassigned index must leave every threshold alone.
        write_reg(CFG_UNUSED_INDEX, $urandom_range(0, 511));

        // Unmarked pixel alone on the frame end gives the empty readout.
        push_px(0, 0, 0, 0, 0, 1'b1);
        push_px(0, 255, 0, 0, 0, 1'b0);
        push_px(9, 11, 0, 1, 1, 1'b0);
        push_px(5, 255, 5, 500, 500, 1'b0);
        push_px(0, 10, 0, 600, 600, 1'b0);
        push_px(255, 255, 255, COORD_MAX, COORD_MAX, 1'b0);
        push_px(0, 11, 0, COORD_MAX, COORD_MAX, 1'b0);
        // Growth to the left keeps the right edge; the margin test is strict.
        push_px(0, 200, 0, 20, 5, 1'b0);
        push_px(0, 200, 0, 19, 5, 1'b0);
        push_px(0, 200, 0, 22, 5, 1'b0);
        push_px(0, 200, 0, 20, 3, 1'b0);
        push_px(0, 200, 0, 25, 5, 1'b1);
        // A pixel between two blobs grows both of them.
        push_px(0, 200, 0, 10, 10, 1'b0);
        push_px(0, 200, 0, 12, 10, 1'b0);
        push_px(0, 200, 0, 11, 10, 1'b0);
        push_px(0, 200, 0, 10, 9, 1'b0);
        push_px(255, 0, 255, 0, COORD_MAX, 1'b1);
        // A green pixel on the frame end starts a blob and is read out at once.
        push_px(0, 255, 9, COORD_MAX, 0, 1'b1);
        wait_drained();

        // Widest thresholds, no margin: the table overflows.
        set_thresholds(511, 0, 0);
        add_crowd(36);
        add_frame(8, 5, 3, 5);
        wait_drained();

        // Nothing can be marked; noise with stray frame ends.
        set_thresholds(0, 255, 255);
        add_noise(14);
        wait_drained();

        // Widest margin, and no idling on either side.
        quiet_mode = 1'b1;
        set_thresholds(300, 128, 255);
        add_frame(8, 5, 4, 10);
        wait_drained();
        quiet_mode = 1'b0;

        // Receiver holds the first readout while the next frame queues up.
        set_thresholds($urandom_range(20, 511), $urandom_range(0, 200),
                       $urandom_range(1, 6));
        hold_requests++;
        add_frame(6, 4, 4, 5);
        add_frame(6, 4, 4, 5);
        wait_drained();

        set_thresholds(10, 10, $urandom_range(1, 4));
        add_frame(6, 4, 4, 10);
        add_noise(12);
        wait_drained();

        $display("Run covered %0d pixels and %0d frame readouts, %0d of them with a full table.",
                 pixels_taken, frames_closed, overflow_frames);
        $display("%0d box results were compared, %0d errors found.", results_checked, errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
